@@ src/ier_pkg.sv @@
// Shared constants, register indexes and datapath types of the int8
// element-wise requantizer. No dependencies.
package ier_pkg;

  localparam int unsigned FRAC = 16;   // fraction bits of every scale
  localparam int unsigned SCW  = 32;   // scale register width

  // magnitude of the exact value before the final division
  localparam int unsigned NNW = 2 * SCW + 15 + SCW;
  // divisor width: a power of two or |vb| << FRAC
  localparam int unsigned DW  = (3 * FRAC + 1 > 40 + FRAC) ? 3 * FRAC + 1 : 40 + FRAC;
  // running remainder, 2n + d, and the shifted divisor
  localparam int unsigned NW  = (NNW + 2 > DW + 9) ? NNW + 2 : DW + 9;
  localparam int unsigned QSTEPS = 8;  // saturation step plus seven result bits

  localparam logic [2:0] OP_MUL = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_MAX = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;

  localparam logic [1:0] REG_OPERATION = 2'd0;
  localparam logic [1:0] REG_SCALE_A   = 2'd1;
  localparam logic [1:0] REG_SCALE_B   = 2'd2;
  localparam logic [1:0] REG_INV_OUT   = 2'd3;

  typedef struct packed {
    logic [2:0]     operation;
    logic [SCW-1:0] scale_a;
    logic [SCW-1:0] scale_b;
    logic [SCW-1:0] inv_out_scale;
  } cfg_t;

  typedef struct packed {
    logic neg;        // sign of the result
    logic special;    // result does not come from the divider
    logic force_max;  // special result has magnitude 127, else 0
    logic dz;         // zero divisor flag
  } side_t;

  typedef struct packed {
    logic [NNW-1:0] n;
    logic [DW-1:0]  d;
    side_t          side;
  } work_t;

endpackage

@@ src/ier_if.sv @@
// Stream interfaces of the requantizer: operand pairs in, results out.
// Depends on nothing.
interface ier_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] operand_a;
  logic signed [7:0] operand_b;
  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface ier_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] result_q;
  logic              div_zero;
  modport source (output valid, output result_q, output div_zero, input ready);
  modport sink (input valid, input result_q, input div_zero, output ready);
endinterface

@@ src/ier_front.sv @@
// Front half of the pipeline: dequantize, apply the operation, multiply by
// the output scale. Five stages. Depends on ier_pkg.
module ier_front import ier_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic signed [7:0] operand_a_i,
  input  logic signed [7:0] operand_b_i,
  input  cfg_t              cfg_i,
  output logic              valid_o,
  output work_t             work_o
);

  // stage 1: operand scaling
  logic               s1_v_q;
  logic [2:0]         s1_op_q;
  logic signed [40:0] s1_va_q, s1_vb_q, va_d, vb_d;
  logic signed [15:0] s1_ab_q, ab_d;
  logic [63:0]        s1_sab_q, sab_d;

  assign va_d  = $signed({{33{operand_a_i[7]}}, operand_a_i}) * $signed({9'b0, cfg_i.scale_a});
  assign vb_d  = $signed({{33{operand_b_i[7]}}, operand_b_i}) * $signed({9'b0, cfg_i.scale_b});
  assign ab_d  = $signed({{8{operand_a_i[7]}}, operand_a_i}) *
                 $signed({{8{operand_b_i[7]}}, operand_b_i});
  assign sab_d = {32'b0, cfg_i.scale_a} * {32'b0, cfg_i.scale_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_op_q  <= cfg_i.operation;
      s1_va_q  <= va_d;
      s1_vb_q  <= vb_d;
      s1_ab_q  <= ab_d;
      s1_sab_q <= sab_d;
    end
  end

  // stage 2: operation, magnitudes, sign
  logic signed [41:0] vae, vbe, v, magv_full;
  logic signed [15:0] magab_full;
  logic signed [40:0] magvb_full;
  logic               vb_zero, va_zero;
  side_t              side_d;
  logic [46:0]        m1_d;

  always_comb begin
    vae = {s1_va_q[40], s1_va_q};
    vbe = {s1_vb_q[40], s1_vb_q};
    case (s1_op_q)
      OP_ADD:  v = vae + vbe;
      OP_SUB:  v = vae - vbe;
      OP_MAX:  v = (vae > vbe) ? vae : vbe;
      default: v = vae;
    endcase
    magv_full  = v[41] ? -v : v;
    magab_full = s1_ab_q[15] ? -s1_ab_q : s1_ab_q;
    magvb_full = s1_vb_q[40] ? -s1_vb_q : s1_vb_q;
    vb_zero    = (s1_vb_q == '0);
    va_zero    = (s1_va_q == '0);
    side_d     = '0;
    case (s1_op_q) inside
      OP_MUL: side_d.neg = s1_ab_q[15];
      OP_ADD, OP_SUB, OP_MAX: side_d.neg = v[41];
      OP_DIV: begin
        side_d.dz        = vb_zero;
        side_d.special   = vb_zero;
        side_d.force_max = vb_zero & ~va_zero;
        side_d.neg       = vb_zero ? s1_va_q[40] : (s1_va_q[40] ^ s1_vb_q[40]);
      end
      default: side_d.special = 1'b1;
    endcase
  end

  assign m1_d = 47'(magab_full[14:0]) * 47'(cfg_i.inv_out_scale);

  logic        s2_v_q, s2_prod_q, s2_quot_q;
  logic [46:0] s2_m1_q;
  logic [40:0] s2_magv_q;
  logic [39:0] s2_magvb_q;
  logic [63:0] s2_sab_q;
  side_t       s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en_i) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_prod_q  <= (s1_op_q == OP_MUL);
      s2_quot_q  <= (s1_op_q == OP_DIV);
      s2_m1_q    <= m1_d;
      s2_magv_q  <= magv_full[40:0];
      s2_magvb_q <= magvb_full[39:0];
      s2_sab_q   <= s1_sab_q;
      s2_side_q  <= side_d;
    end
  end

  // stage 3: partial products of a 64 x 47 multiply, and the divisor
  logic [63:0]   mul_a;
  logic [46:0]   mul_b;
  logic [DW-1:0] d_d;

  always_comb begin
    mul_a = s2_prod_q ? s2_sab_q : {23'b0, s2_magv_q};
    mul_b = s2_prod_q ? s2_m1_q : {15'b0, cfg_i.inv_out_scale};
    if (s2_prod_q) begin
      d_d = DW'(1) << (3 * FRAC);
    end else if (s2_quot_q) begin
      d_d = DW'(s2_magvb_q) << FRAC;
    end else begin
      d_d = DW'(1) << (2 * FRAC);
    end
  end

  logic          s3_v_q;
  logic [63:0]   s3_p0_q, s3_p1_q;
  logic [46:0]   s3_p2_q, s3_p3_q;
  logic [DW-1:0] s3_d_q;
  side_t         s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en_i) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_p0_q   <= {32'b0, mul_a[31:0]} * {32'b0, mul_b[31:0]};
      s3_p1_q   <= {32'b0, mul_a[63:32]} * {32'b0, mul_b[31:0]};
      s3_p2_q   <= 47'(mul_a[31:0]) * 47'(mul_b[46:32]);
      s3_p3_q   <= 47'(mul_a[63:32]) * 47'(mul_b[46:32]);
      s3_d_q    <= d_d;
      s3_side_q <= s2_side_q;
    end
  end

  // stage 4: two half sums; stage 5: full product
  logic          s4_v_q, s5_v_q;
  logic [95:0]   s4_lo_q;
  logic [78:0]   s4_hi_q;
  logic [DW-1:0] s4_d_q;
  side_t         s4_side_q;
  work_t         s5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (en_i) begin
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_lo_q   <= 96'(s3_p0_q) + (96'(s3_p1_q) << 32);
      s4_hi_q   <= 79'(s3_p2_q) + (79'(s3_p3_q) << 32);
      s4_d_q    <= s3_d_q;
      s4_side_q <= s3_side_q;
      s5_q.n    <= NNW'(s4_lo_q) + (NNW'(s4_hi_q) << 32);
      s5_q.d    <= s4_d_q;
      s5_q.side <= s4_side_q;
    end
  end

  assign valid_o = s5_v_q;
  assign work_o  = s5_q;

endmodule

@@ src/ier_div.sv @@
// Back half: rounded division n / d by restoring steps, one bit a stage,
// saturation and sign. Nine stages. Depends on ier_pkg.
module ier_div import ier_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  work_t             work_i,
  output logic              valid_o,
  output logic signed [7:0] result_q_o,
  output logic              div_zero_o
);

  logic          v_q   [QSTEPS+1];
  logic [NW-1:0] num_q [QSTEPS+1];
  logic [DW-1:0] d_q   [QSTEPS+1];
  logic [7:0]    q_q   [QSTEPS+1];
  side_t         side_q[QSTEPS+1];

  // round half away: floor((2n + d) / 2d)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]  <= (NW'(work_i.n) << 1) + NW'(work_i.d);
      d_q[0]    <= work_i.d;
      q_q[0]    <= '0;
      side_q[0] <= work_i.side;
    end
  end

  for (genvar i = 1; i <= QSTEPS; i++) begin : g_step
    localparam int unsigned K = QSTEPS - i;  // bit decided here; top bit saturates
    logic [NW-1:0] t;
    logic          ge;

    assign t  = NW'(d_q[i-1]) << (K + 1);
    assign ge = (num_q[i-1] >= t);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[i]  <= ge ? num_q[i-1] - t : num_q[i-1];
        d_q[i]    <= d_q[i-1];
        q_q[i]    <= q_q[i-1] | (8'(ge) << K);
        side_q[i] <= side_q[i-1];
      end
    end
  end

  logic [6:0] mag;
  side_t      fin;

  always_comb begin
    fin = side_q[QSTEPS];
    if (fin.special) begin
      mag = fin.force_max ? 7'd127 : 7'd0;
    end else begin
      mag = q_q[QSTEPS][7] ? 7'd127 : q_q[QSTEPS][6:0];
    end
  end

  assign valid_o    = v_q[QSTEPS];
  assign result_q_o = fin.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign div_zero_o = fin.dz;

endmodule

@@ src/int8_eltwise_requant_top.sv @@
// Requantizing int8 element-wise binary operation, top level.
// Holds the configuration registers and the pipeline enable.
// Uses ier_pkg, ier_if, ier_front and ier_div.
//
// Channels: in_i carries operand pairs (operand_a, operand_b), out_o one
// result per pair (result_q, div_zero), both valid/ready; a beat moves
// when valid and ready are high at a rising edge.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 operation, 1 scale_a, 2 scale_b, 3 inv_out_scale); write only while
// no beat is in flight.
// Pipeline: 14 registered stages from input beat to output valid (five
// multiply and sum stages, one rounding stage, eight one-bit divide stages).
// Throughput: one pair per cycle while out_o takes its beats; every stage
// is registered and all 14 stages move together.
// Stall: while out_o holds a beat that is not taken, the whole pipeline
// and in_i.ready hold; nothing is dropped or duplicated.
// Reset: clears all valid bits and loads operation 0 and unity scales.
module int8_eltwise_requant_top import ier_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  ier_in_if.sink         in_i,
  ier_out_if.source      out_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [SCW-1:0] cfg_data_i
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.operation     <= OP_MUL;
      cfg_q.scale_a       <= SCW'(1) << FRAC;
      cfg_q.scale_b       <= SCW'(1) << FRAC;
      cfg_q.inv_out_scale <= SCW'(1) << FRAC;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OPERATION: cfg_q.operation     <= cfg_data_i[2:0];
        REG_SCALE_A:   cfg_q.scale_a       <= cfg_data_i;
        REG_SCALE_B:   cfg_q.scale_b       <= cfg_data_i;
        REG_INV_OUT:   cfg_q.inv_out_scale <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic  en;
  logic  front_v;
  work_t front_work;

  assign en         = ~out_o.valid | out_o.ready;
  assign in_i.ready = en;

  ier_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_i.valid),
    .operand_a_i (in_i.operand_a),
    .operand_b_i (in_i.operand_b),
    .cfg_i       (cfg_q),
    .valid_o     (front_v),
    .work_o      (front_work)
  );

  ier_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (front_v),
    .work_i     (front_work),
    .valid_o    (out_o.valid),
    .result_q_o (out_o.result_q),
    .div_zero_o (out_o.div_zero)
  );

`ifndef SYNTHESIS
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.result_q != 8'sh80)
    else $error("result -128 produced");

  a_dz_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.div_zero |-> cfg_q.operation == OP_DIV)
    else $error("zero divisor flag outside quotient mode");

  a_dz_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.div_zero |->
      (out_o.result_q == 8'sh7f || out_o.result_q == 8'sh81 || out_o.result_q == 8'sh00))
    else $error("zero divisor result not +-127 or 0");

  a_unused_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && cfg_q.operation > OP_DIV |-> out_o.result_q == 8'sh00)
    else $error("unused operation gave nonzero result");
`endif

endmodule
